@@ hw/rtl/cad_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cad_pkg;

  // Field widths
  localparam int MV_W       = 14;
  localparam int REQ_W      = 8;
  localparam int SPW_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  // Moving average length (number of cells in the sample line)
  localparam int AVG_LEN = 6;

  // Running sum holds AVG_LEN samples
  localparam int SUM_W = MV_W + $clog2(AVG_LEN);

  // Floor division by AVG_LEN as multiply by a rounded-up reciprocal.
  // Exact for every sum below 2**SUM_W since the rounding error is below AVG_LEN.
  localparam int DIV_SHIFT  = SUM_W + $clog2(AVG_LEN);
  localparam int DIV_MULT   = ((1 << DIV_SHIFT) + AVG_LEN - 1) / AVG_LEN;
  localparam int DIV_MULT_W = $clog2(DIV_MULT + 1);
  localparam int PROD_W     = SUM_W + DIV_MULT_W;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_REQUIRED  = 2'd1,
    CFG_SPW       = 2'd2
  } cfg_idx_t;

  // One averaged sample handed to the peak stage
  typedef struct packed {
    logic            had;   // average valid for this sample
    logic            last;  // sample closes the window
    logic [MV_W-1:0] avg;
  } avg_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/cad_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cad_cell (
  input  logic                   clk,
  input  logic                   en,
  input  logic [cad_pkg::MV_W-1:0] d,
  output logic [cad_pkg::MV_W-1:0] q
);
  import cad_pkg::*;

  logic [MV_W-1:0] q_r;

  // One tap of the sample line, shifts on every accepted sample
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

@@ hw/rtl/cad_peak.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cad_peak (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      req_valid,
  input  cad_pkg::avg_req_t         req,
  output logic                      req_ack,
  input  logic [cad_pkg::MV_W-1:0]  threshold_mv,
  input  logic [cad_pkg::REQ_W-1:0] required_windows,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [cad_pkg::MV_W-1:0]  out_diff_mv,
  output logic                      out_window_ok,
  output logic                      out_decided,
  output logic                      out_active
);
  import cad_pkg::*;

  logic [MV_W-1:0]  min_r, min_nxt;
  logic [MV_W-1:0]  max_r, max_nxt;
  logic [REQ_W-1:0] pw_r, pw_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [MV_W-1:0]  diff_r;
  logic             ok_r, decided_r, active_r;

  logic             out_free;
  logic [MV_W-1:0]  min_upd, max_upd, diff_w;
  logic             ok_w, decided_w, active_w;
  logic [REQ_W-1:0] need_w;
  logic [REQ_W:0]   pw_inc;

  // A request that closes a window needs room in the output register
  assign out_free = !out_valid_r || !out_stall;
  assign req_ack  = req_valid && (!req.last || out_free);

  // Independent min and max tracking of the average
  assign min_upd = (req.had && (req.avg < min_r)) ? req.avg : min_r;
  assign max_upd = (req.had && (req.avg > max_r)) ? req.avg : max_r;

  // Peak-to-peak; zero when the window never produced an average
  assign diff_w = req.had ? (max_upd - min_upd) : '0;
  assign ok_w   = (diff_w >= threshold_mv);
  assign need_w = (required_windows == '0) ? REQ_W'(1) : required_windows;
  assign pw_inc = {1'b0, pw_r} + (REQ_W + 1)'(1);

  // Run counting and decision
  always_comb begin
    decided_w = 1'b0;
    active_w  = 1'b0;
    pw_nxt    = pw_r;
    priority if (!ok_w) begin
      decided_w = 1'b1;
      pw_nxt    = '0;
    end else if ((pw_inc[REQ_W-1:0] >= need_w) || pw_inc[REQ_W]) begin
      decided_w = 1'b1;
      active_w  = 1'b1;
      pw_nxt    = '0;
    end else begin
      pw_nxt    = pw_inc[REQ_W-1:0];
    end
  end

  // Window tracking resets after a window ends
  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (req_ack) begin
      if (req.last) begin
        min_nxt = '1;
        max_nxt = '0;
      end else begin
        min_nxt = min_upd;
        max_nxt = max_upd;
      end
    end
  end

  assign out_valid_nxt = (req_ack && req.last) ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= '1;
      max_r       <= '0;
      pw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
      if (req_ack && req.last) begin
        pw_r <= pw_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (req_ack && req.last) begin
      diff_r    <= diff_w;
      ok_r      <= ok_w;
      decided_r <= decided_w;
      active_r  <= active_w;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_diff_mv   = diff_r;
  assign out_window_ok = ok_r;
  assign out_decided   = decided_r;
  assign out_active    = active_r;

endmodule

`default_nettype wire

@@ hw/rtl/current_activity_detector_unit.sv @@
// Current activity detector.
// Input channel: one millivolt sample per request on in_sample_mv, taken when
// in_valid is high and in_stall low. A sample line of six cells keeps the last
// six samples for a running sum; the average is the floor of sum / 6.
// Result channel: one request per window (samples_per_window samples) with the
// peak-to-peak of the average, the threshold verdict and the evaluation outcome.
// Configuration: cfg_valid/cfg_ready write channel, index 0 threshold_mv,
// 1 required_windows, 2 samples_per_window; cfg_ready is always high.
// Throughput: one sample per cycle while in_stall is low; the running sum update
// is a single add and subtract loop.
// Result path: once its last sample is accepted, a window's result passes the sum
// stage, reciprocal multiply stage and peak stage before it appears on out_valid.
// Reset: synchronous, active low; restores register defaults and clears window
// and run state; no results are pending afterwards.
// Stall: a waiting result holds out_* stable; samples that do not close a window
// keep flowing, and in_stall rises only once the pipeline is full behind it.
`timescale 1ns / 1ps
`default_nettype none

module current_activity_detector_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cad_pkg::MV_W-1:0]       in_sample_mv,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cad_pkg::MV_W-1:0]       out_diff_mv,
  output logic                           out_window_ok,
  output logic                           out_decided,
  output logic                           out_active,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cad_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cad_pkg::*;

  // Configuration registers
  logic [MV_W-1:0]  threshold_r;
  logic [REQ_W-1:0] required_r;
  logic [SPW_W-1:0] spw_r;

  // Window state
  logic [SPW_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  // Pipeline stages
  logic             s0_valid_r, s0_valid_nxt;
  logic [SUM_W-1:0] s0_sum_r;
  logic             s0_had_r, s0_last_r;
  logic             s1_valid_r, s1_valid_nxt;
  avg_req_t         s1_req_r;

  logic             in_acc, go0, go1;
  logic [MV_W-1:0]  cell_q [AVG_LEN];
  logic             had_w, last_w;
  logic [SUM_W-1:0] sub_w, sum_upd;
  logic [SPW_W:0]   cnt_inc;
  logic [PROD_W-1:0] prod_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= MV_W'(100);
      required_r  <= REQ_W'(5);
      spw_r       <= SPW_W'(200);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_THRESHOLD: threshold_r <= cfg_data[MV_W-1:0];
        CFG_REQUIRED:  required_r  <= cfg_data[REQ_W-1:0];
        CFG_SPW:       spw_r       <= cfg_data[SPW_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: stall only when the sum stage cannot move on
  assign go0      = s0_valid_r && (!s1_valid_r || go1);
  assign in_stall = s0_valid_r && !go0;
  assign in_acc   = in_valid && !in_stall;

  // Sample line of cells
  genvar gi;
  generate
    for (gi = 0; gi < AVG_LEN; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        cad_cell u_cell (.clk(clk), .en(in_acc), .d(in_sample_mv), .q(cell_q[gi]));
      end else begin : g_tail
        cad_cell u_cell (.clk(clk), .en(in_acc), .d(cell_q[gi-1]), .q(cell_q[gi]));
      end
    end
  endgenerate

  // Running sum over the last AVG_LEN samples of the window
  assign had_w   = (count_r >= SPW_W'(AVG_LEN));
  assign sub_w   = had_w ? SUM_W'(cell_q[AVG_LEN-1]) : '0;
  assign sum_upd = sum_r - sub_w + SUM_W'(in_sample_mv);
  assign cnt_inc = {1'b0, count_r} + (SPW_W + 1)'(1);
  assign last_w  = (cnt_inc >= {1'b0, spw_r});

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (in_acc) begin
      if (last_w) begin
        count_nxt = '0;
        sum_nxt   = '0;
      end else begin
        count_nxt = cnt_inc[SPW_W-1:0];
        sum_nxt   = sum_upd;
      end
    end
  end

  assign s0_valid_nxt = in_acc ? 1'b1 : (go0 ? 1'b0 : s0_valid_r);
  assign s1_valid_nxt = go0 ? 1'b1 : (go1 ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      sum_r      <= '0;
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      sum_r      <= sum_nxt;
      s0_valid_r <= s0_valid_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Sum stage register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_sum_r  <= sum_upd;
      s0_had_r  <= had_w;
      s0_last_r <= last_w;
    end
  end

  // Divide by AVG_LEN through reciprocal multiply
  assign prod_w = PROD_W'(s0_sum_r) * PROD_W'(DIV_MULT);

  always_ff @(posedge clk) begin
    if (go0) begin
      s1_req_r.had  <= s0_had_r;
      s1_req_r.last <= s0_last_r;
      s1_req_r.avg  <= prod_w[DIV_SHIFT +: MV_W];
    end
  end

  // Min/max tracking, run counting and result register
  cad_peak u_peak (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (s1_valid_r),
    .req              (s1_req_r),
    .req_ack          (go1),
    .threshold_mv     (threshold_r),
    .required_windows (required_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_diff_mv      (out_diff_mv),
    .out_window_ok    (out_window_ok),
    .out_decided      (out_decided),
    .out_active       (out_active)
  );

endmodule

`default_nettype wire

@@ hw/rtl/cad_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cad_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [cad_pkg::MV_W-1:0]       in_sample_mv,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [cad_pkg::MV_W-1:0]       out_diff_mv,
  input logic                           out_window_ok,
  input logic                           out_decided,
  input logic                           out_active,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [cad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [cad_pkg::CFG_DATA_W-1:0] cfg_data
);

  // A stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_diff_mv) && $stable(out_active))
    else $error("stalled result changed");

  // Active only comes with a decision
  a_active_decided: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_active |-> out_decided && out_window_ok)
    else $error("active without decision or passing window");

  // A failing window always ends the evaluation as inactive
  a_fail_decides: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_window_ok |-> out_decided && !out_active)
    else $error("failing window did not decide inactive");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind current_activity_detector_unit cad_checker u_cad_checker (.*);

`default_nettype wire

@@ sim/current_activity_detector_unit_tb.sv @@
`timescale 1ns / 1ps

module current_activity_detector_unit_tb;
  import cad_pkg::*;

  localparam int MV_MAX      = (1 << MV_W) - 1;
  localparam int SETTLE      = 8;      // cycles past the last result before a register write
  localparam int STALL_LIMIT = 1000;   // cycles without any accepted request
  localparam int RANDOM_ITEMS = 380;

  // One window verdict as the block reports it
  typedef struct {
    logic [MV_W-1:0] diff;
    logic            ok;
    logic            decided;
    logic            active;
  } window_verdict_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [MV_W-1:0] in_sample_mv;
  logic out_valid;
  logic out_stall;
  logic [MV_W-1:0] out_diff_mv;
  logic out_window_ok;
  logic out_decided;
  logic out_active;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor copy of the registers
  logic [MV_W-1:0]  thr_reg;
  logic [REQ_W-1:0] req_reg;
  logic [SPW_W-1:0] spw_reg;

  // Predictor copy of the window and run state
  logic [MV_W-1:0]  avg_line [AVG_LEN];
  int unsigned      line_pos;
  logic [SUM_W-1:0] line_sum;
  logic [SPW_W-1:0] win_count;
  logic [MV_W-1:0]  avg_lo;
  logic [MV_W-1:0]  avg_hi;
  logic [REQ_W-1:0] run_len;

  window_verdict_t window_expect[$];

  int  mismatches;
  int  idle_cycles;
  bit  sender_gaps;
  bit  sink_stalls;
  int  stall_hold;

  current_activity_detector_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_mv (in_sample_mv),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_diff_mv  (out_diff_mv),
    .out_window_ok(out_window_ok),
    .out_decided  (out_decided),
    .out_active   (out_active),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [MV_W-1:0] clip_mv(input int v);
    if (v > MV_MAX) return MV_MAX[MV_W-1:0];
    if (v < 0) return '0;
    return MV_W'(v);
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < AVG_LEN; i++) avg_line[i] = '0;
    line_pos  = 0;
    line_sum  = '0;
    win_count = '0;
    avg_lo    = '1;
    avg_hi    = '0;
  endfunction

  // Fold one accepted sample into the predicted state; a closing sample queues a verdict
  function automatic void fold_sample(input logic [MV_W-1:0] s);
    logic            had_avg;
    logic [MV_W-1:0] avg;
    logic [REQ_W-1:0] need;
    window_verdict_t v;
    had_avg = (win_count >= AVG_LEN);
    if (had_avg) line_sum = line_sum - avg_line[line_pos];
    line_sum = line_sum + s;
    avg_line[line_pos] = s;
    line_pos = (line_pos + 1) % AVG_LEN;
    if (had_avg) begin
      avg = MV_W'(line_sum / AVG_LEN);
      if (avg < avg_lo) avg_lo = avg;
      if (avg > avg_hi) avg_hi = avg;
    end
    if (int'(win_count) + 1 < int'(spw_reg)) begin
      win_count = win_count + 1'b1;
      return;
    end
    v.diff    = (had_avg && avg_hi >= avg_lo) ? avg_hi - avg_lo : '0;
    v.ok      = (v.diff >= thr_reg);
    v.decided = 1'b0;
    v.active  = 1'b0;
    need = (req_reg == 0) ? 8'd1 : req_reg;
    if (!v.ok) begin
      v.decided = 1'b1;
      run_len   = '0;
    end else begin
      run_len = run_len + 1'b1;
      if (run_len >= need || run_len == 0) begin
        v.decided = 1'b1;
        v.active  = 1'b1;
        run_len   = '0;
      end
    end
    clear_window();
    window_expect.push_back(v);
  endfunction

  function automatic void report_mismatch(input string what);
    if (mismatches < 10) $display("[%0t] %s", $realtime, what);
    mismatches++;
  endfunction

  // Result checker
  always @(posedge clk) begin
    window_verdict_t exp_v;
    if (rst_n && out_valid && !out_stall) begin
      if (window_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected result diff=%0d ok=%0b dec=%0b act=%0b",
                                  out_diff_mv, out_window_ok, out_decided, out_active));
      end else begin
        exp_v = window_expect.pop_front();
        if (out_diff_mv !== exp_v.diff || out_window_ok !== exp_v.ok ||
            out_decided !== exp_v.decided || out_active !== exp_v.active)
          report_mismatch($sformatf(
            "expected diff=%0d ok=%0b dec=%0b act=%0b, got diff=%0d ok=%0b dec=%0b act=%0b",
            exp_v.diff, exp_v.ok, exp_v.decided, exp_v.active,
            out_diff_mv, out_window_ok, out_decided, out_active));
      end
    end
  end

  // Receiver stall pattern
  always @(negedge clk) begin
    if (!rst_n || !sink_stalls) begin
      out_stall  <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_hold = pick_gap();
    end
  end

  // Watchdog on cycles with no accepted request
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_sample(input logic [MV_W-1:0] s);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_mv <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_sample(s);
  endtask

  // Drop valid and wait for every pending verdict, then let the pipeline settle
  task automatic await_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (window_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_THRESHOLD: thr_reg = value;
      CFG_REQUIRED:  req_reg = value[REQ_W-1:0];
      CFG_SPW:       spw_reg = value[SPW_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Register defaults: one full-swing window of 200 samples passes but does not decide
  task automatic test_reset_defaults();
    for (int i = 0; i < 200; i++) send_sample(i < 100 ? MV_MAX[MV_W-1:0] : '0);
    await_idle();
  endtask

  // Short windows of 0, 1, 3 and 7 samples, zero required windows; only the 7-sample ones take an average
  task automatic test_short_windows();
    write_reg(CFG_THRESHOLD, '0);
    write_reg(CFG_REQUIRED, '0);
    write_reg(CFG_SPW, '0);
    repeat (3) send_sample(MV_W'($urandom_range(0, MV_MAX)));
    await_idle();
    write_reg(CFG_SPW, 14'd1);
    send_sample(MV_MAX[MV_W-1:0]);
    send_sample('0);
    await_idle();
    write_reg(CFG_SPW, 14'd3);
    repeat (6) send_sample(MV_W'($urandom_range(0, MV_MAX)));
    await_idle();
    write_reg(CFG_THRESHOLD, 14'd1);
    repeat (3) send_sample(MV_W'($urandom_range(0, MV_MAX)));
    await_idle();
    write_reg(CFG_THRESHOLD, '0);
    write_reg(CFG_SPW, 14'd7);
    repeat (7) send_sample(MV_W'($urandom_range(0, MV_MAX)));
    await_idle();
  endtask

  // Window length lowered below the current count: next sample closes it
  task automatic test_lowered_window();
    write_reg(CFG_SPW, 14'd50);
    write_reg(CFG_THRESHOLD, 14'd20);
    for (int i = 0; i < 20; i++) send_sample((i % 8 < 4) ? 14'd3000 : 14'd100);
    await_idle();
    write_reg(CFG_SPW, 14'd10);
    send_sample(14'd50);
    await_idle();
  endtask

  // Largest run length: 255 passing windows, then the run counter starts again
  task automatic test_required_max();
    write_reg(CFG_THRESHOLD, '0);
    write_reg(CFG_REQUIRED, 14'h3FFF);
    write_reg(CFG_SPW, 14'd1);
    for (int i = 0; i < 257; i++) send_sample(i[MV_W-1:0]);
    await_idle();
  endtask

  // Highest threshold, reached exactly by a full-swing window
  task automatic test_max_threshold();
    write_reg(CFG_REQUIRED, 14'd1);
    write_reg(CFG_THRESHOLD, MV_MAX[MV_W-1:0]);
    write_reg(CFG_SPW, 14'd40);
    for (int i = 0; i < 40; i++) send_sample(i < 20 ? MV_MAX[MV_W-1:0] : '0);
    await_idle();
  endtask

  // Random phases: random registers, whole windows of shaped random samples
  task automatic test_random_windows();
    int sent;
    int phase;
    int kind;
    int base;
    int amp;
    int half;
    int n_items;
    int spw;
    int r;
    int v;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70)      spw = $urandom_range(7, 24);
      else if (r < 90) spw = $urandom_range(25, 80);
      else             spw = $urandom_range(0, 6);
      kind = $urandom_range(0, 2);
      base = $urandom_range(0, MV_MAX);
      amp  = $urandom_range(0, MV_MAX - base);
      half = $urandom_range(3, 20);
      write_reg(CFG_SPW, {2'($urandom), 12'(spw)});
      write_reg(CFG_REQUIRED, {6'($urandom),
                               8'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 4)
                                                             : $urandom_range(0, 8))});
      r = $urandom_range(0, 3);
      if (r < 2)       v = $urandom_range(amp / 2, amp + amp / 2);
      else if (r == 2) v = $urandom_range(0, MV_MAX);
      else             v = $urandom_range(0, 10);
      write_reg(CFG_THRESHOLD, clip_mv(v));
      sender_gaps = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      n_items = $urandom_range(2, 6) * ((spw < 1) ? 1 : spw);
      for (int i = 0; i < n_items; i++) begin
        // once, the sender holds off mid-phase until all verdicts are in
        if (phase == 2 && i == n_items / 2) await_idle();
        case (kind)
          0:       v = base + $urandom_range(0, 3);
          1:       v = (((i / half) % 2) ? base + amp : base) + $urandom_range(0, 3);
          default: v = $urandom_range(0, MV_MAX);
        endcase
        send_sample(clip_mv(v));
      end
      sent += n_items;
      phase++;
      await_idle();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_mv = '0;
    out_stall    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_THRESHOLD;
    cfg_data     = '0;
    mismatches   = 0;
    idle_cycles  = 0;
    stall_hold   = 0;
    sender_gaps  = 1'b1;
    sink_stalls  = 1'b1;
    thr_reg      = 14'd100;
    req_reg      = 8'd5;
    spw_reg      = 12'd200;
    run_len      = '0;
    clear_window();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_short_windows();
    test_lowered_window();
    test_required_max();
    test_max_threshold();
    test_random_windows();

    await_idle();
    if (window_expect.size() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived", window_expect.size()));
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ current_activity_detector_unit.f @@
hw/rtl/cad_pkg.sv
hw/rtl/cad_cell.sv
hw/rtl/cad_peak.sv
hw/rtl/current_activity_detector_unit.sv
hw/rtl/cad_checker.sv
sim/current_activity_detector_unit_tb.sv
